// File: rtl/jsu_pkg.sv
`timescale 1ns / 1ps
// jsu_pkg: shared types and constants of the json string unescaper
// no dependencies; used by every rtl module but jsu_if

package jsu_pkg;

   // result kinds
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // end of string status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_CONTROL   = 3'd1;
   localparam logic [2:0] ST_BAD_ESC   = 3'd2;
   localparam logic [2:0] ST_BAD_HEX   = 3'd3;
   localparam logic [2:0] ST_UNPAIRED  = 3'd4;
   localparam logic [2:0] ST_LONE_LOW  = 3'd5;
   localparam logic [2:0] ST_TRUNCATED = 3'd6;
   localparam logic [2:0] ST_NO_OPEN   = 3'd7;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // utf-8 bytes one input byte can produce
   localparam int MAX_DATA = 4;

   // one classified input byte: its data bytes, then an optional status
   typedef struct packed {
      logic [2:0]                data_count;
      logic [MAX_DATA-1:0][7:0]  data;
      logic                      has_status;
      logic [2:0]                status;
   } cmd_type;

   // front to queue
   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } qwr_type;

   // queue head to back
   typedef struct packed {
      logic    not_empty;
      cmd_type cmd;
   } qrd_type;

endpackage

// File: rtl/jsu_if.sv
`timescale 1ns / 1ps
// jsu_req_if and jsu_rsp_if: valid/ready channels of the json string unescaper
// depends on nothing; payload widths follow the block's field list

interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_input;

   modport source (output valid, output data_byte, output end_of_input, input ready);
   modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic       out_kind;
   logic [7:0] out_byte;
   logic [2:0] status;
   logic       run_last;

   modport source (output valid, output out_kind, output out_byte, output status,
                   output run_last, input ready);
   modport sink   (input valid, input out_kind, input out_byte, input status,
                   input run_last, output ready);
endinterface

// File: rtl/jsu_front.sv
`timescale 1ns / 1ps
// jsu_front: takes raw bytes, runs the string parser and builds result commands
// depends on jsu_pkg and jsu_req_if

module jsu_front
   import jsu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   jsu_req_if.sink   req_chan,
   input  logic      q_full,
   output qwr_type   q_wr
);

   typedef enum logic [2:0] {
      PH_OPEN,
      PH_TEXT,
      PH_ESC,
      PH_HEX,
      PH_PAIR_BS,
      PH_PAIR_U,
      PH_PAIR_HEX,
      PH_DRAIN
   } phase_type;

   // {valid, value} of a hex digit character
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

   phase_type   phase_ff, phase_in;
   logic [1:0]  hex_cnt_ff, hex_cnt_in;
   logic [11:0] acc_ff, acc_in;
   logic [9:0]  high_ff, high_in;

   logic        accept;
   logic [7:0]  b;
   logic        eoi;
   logic [4:0]  hv;
   logic [15:0] code16;
   logic        digit_done;
   logic [20:0] cp;
   logic        emit_cp;
   logic [2:0]  err;
   logic        ended;
   cmd_type     cmd;

   assign req_chan.ready = !q_full;
   assign accept = req_chan.valid && req_chan.ready;
   assign b      = req_chan.data_byte;
   assign eoi    = req_chan.end_of_input;

   // hex digit shifted in behind the three held digits
   assign hv         = hex_value(b);
   assign code16     = {acc_ff, hv[3:0]};
   assign digit_done = (hex_cnt_ff == 2'd3);

   // parser step for one byte
   always_comb begin
      phase_in   = phase_ff;
      hex_cnt_in = hex_cnt_ff;
      acc_in     = acc_ff;
      high_in    = high_ff;
      cp         = '0;
      emit_cp    = 1'b0;
      err        = ST_OK;
      ended      = 1'b0;
      cmd        = '0;

      unique case (phase_ff)
         PH_OPEN: begin
            if (b == 8'h22) phase_in = PH_TEXT;
            else err = ST_NO_OPEN;
         end
         PH_TEXT: begin
            if (b == 8'h22) begin
               cmd.has_status = 1'b1;
               cmd.status     = ST_OK;
               phase_in       = PH_OPEN;
               hex_cnt_in     = 2'd0;
               acc_in         = '0;
               ended          = 1'b1;
            end else if (b < 8'h20) begin
               err = ST_CONTROL;
            end else if (b == 8'h5C) begin
               phase_in = PH_ESC;
            end else begin
               cmd.data_count = 3'd1;
               cmd.data[0]    = b;
            end
         end
         PH_ESC: begin
            phase_in = PH_TEXT;
            case (b)
               8'h22, 8'h5C, 8'h2F: begin
                  cmd.data_count = 3'd1;
                  cmd.data[0]    = b;
               end
               8'h62: begin cmd.data_count = 3'd1; cmd.data[0] = 8'h08; end
               8'h66: begin cmd.data_count = 3'd1; cmd.data[0] = 8'h0C; end
               8'h6E: begin cmd.data_count = 3'd1; cmd.data[0] = 8'h0A; end
               8'h72: begin cmd.data_count = 3'd1; cmd.data[0] = 8'h0D; end
               8'h74: begin cmd.data_count = 3'd1; cmd.data[0] = 8'h09; end
               8'h75: begin
                  phase_in   = PH_HEX;
                  hex_cnt_in = 2'd0;
                  acc_in     = '0;
               end
               default: err = ST_BAD_ESC;
            endcase
         end
         PH_HEX: begin
            if (!hv[4]) begin
               err = ST_BAD_HEX;
            end else if (!digit_done) begin
               hex_cnt_in = hex_cnt_ff + 2'd1;
               acc_in     = code16[11:0];
            end else if (code16 >= 16'hD800 && code16 <= 16'hDBFF) begin
               high_in    = code16[9:0];
               phase_in   = PH_PAIR_BS;
               hex_cnt_in = 2'd0;
               acc_in     = '0;
            end else if (code16 >= 16'hDC00 && code16 <= 16'hDFFF) begin
               err = ST_LONE_LOW;
            end else begin
               cp         = {5'd0, code16};
               emit_cp    = 1'b1;
               phase_in   = PH_TEXT;
               hex_cnt_in = 2'd0;
               acc_in     = '0;
            end
         end
         PH_PAIR_BS: begin
            if (b == 8'h5C) phase_in = PH_PAIR_U;
            else err = ST_UNPAIRED;
         end
         PH_PAIR_U: begin
            if (b == 8'h75) begin
               phase_in   = PH_PAIR_HEX;
               hex_cnt_in = 2'd0;
               acc_in     = '0;
            end else begin
               err = ST_UNPAIRED;
            end
         end
         PH_PAIR_HEX: begin
            if (!hv[4]) begin
               err = ST_BAD_HEX;
            end else if (!digit_done) begin
               hex_cnt_in = hex_cnt_ff + 2'd1;
               acc_in     = code16[11:0];
            end else if (code16 >= 16'hDC00 && code16 <= 16'hDFFF) begin
               cp         = 21'h10000 + {1'b0, high_ff, code16[9:0]};
               emit_cp    = 1'b1;
               phase_in   = PH_TEXT;
               hex_cnt_in = 2'd0;
               acc_in     = '0;
            end else begin
               err = ST_UNPAIRED;
            end
         end
         PH_DRAIN: begin
            if (eoi) begin
               phase_in   = PH_OPEN;
               hex_cnt_in = 2'd0;
               acc_in     = '0;
            end
            ended = 1'b1;
         end
      endcase

      // utf-8 encoding of a decoded code point
      if (emit_cp) begin
         if (cp <= 21'h7F) begin
            cmd.data_count = 3'd1;
            cmd.data[0]    = {1'b0, cp[6:0]};
         end else if (cp <= 21'h7FF) begin
            cmd.data_count = 3'd2;
            cmd.data[0]    = {3'b110, cp[10:6]};
            cmd.data[1]    = {2'b10, cp[5:0]};
         end else if (cp <= 21'hFFFF) begin
            cmd.data_count = 3'd3;
            cmd.data[0]    = {4'b1110, cp[15:12]};
            cmd.data[1]    = {2'b10, cp[11:6]};
            cmd.data[2]    = {2'b10, cp[5:0]};
         end else begin
            cmd.data_count = 3'd4;
            cmd.data[0]    = {5'b11110, cp[20:18]};
            cmd.data[1]    = {2'b10, cp[17:12]};
            cmd.data[2]    = {2'b10, cp[11:6]};
            cmd.data[3]    = {2'b10, cp[5:0]};
         end
      end

      // error ends the string, then drain unless input ends here
      if (err != ST_OK) begin
         cmd.has_status = 1'b1;
         cmd.status     = err;
         phase_in       = eoi ? PH_OPEN : PH_DRAIN;
         hex_cnt_in     = 2'd0;
         acc_in         = '0;
         ended          = 1'b1;
      end

      // input ends with the string still open
      if (!ended && eoi) begin
         cmd.has_status = 1'b1;
         cmd.status     = ST_TRUNCATED;
         phase_in       = PH_OPEN;
         hex_cnt_in     = 2'd0;
         acc_in         = '0;
      end
   end

   // only bytes with results reach the queue
   assign q_wr.push = accept && ((cmd.data_count != 3'd0) || cmd.has_status);
   assign q_wr.cmd  = cmd;

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_OPEN;
         hex_cnt_ff <= 2'd0;
         acc_ff     <= '0;
         high_ff    <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         hex_cnt_ff <= hex_cnt_in;
         acc_ff     <= acc_in;
         high_ff    <= high_in;
      end
   end

endmodule

// File: rtl/jsu_queue.sv
`timescale 1ns / 1ps
// jsu_queue: small command fifo between parser front and result back
// depends on jsu_pkg

module jsu_queue
   import jsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  qwr_type q_wr,
   output logic    q_full,
   output qrd_type q_rd,
   input  logic    q_pop
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign q_full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_rd.not_empty = (count_ff != '0);
   assign q_rd.cmd     = entry_ff[rd_ptr_ff];

   assign do_push = q_wr.push && !q_full;
   assign do_pop  = q_pop && q_rd.not_empty;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + QCNT_W'(1);
      else if (!do_push && do_pop) count_in = count_ff - QCNT_W'(1);
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_wr.cmd;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/jsu_back.sv
`timescale 1ns / 1ps
// jsu_back: expands queued commands into results, one transfer per ready cycle
// depends on jsu_pkg and jsu_rsp_if

module jsu_back
   import jsu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  qrd_type   q_rd,
   output logic      q_pop,
   jsu_rsp_if.source rsp_chan
);

   logic       valid_ff;
   logic       kind_ff;
   logic [7:0] byte_ff;
   logic [2:0] status_ff;
   logic       last_ff;
   logic [2:0] idx_ff;

   logic       out_free;
   logic       emit;
   logic [2:0] total;
   logic       is_data;
   logic       is_last;

   assign total    = q_rd.cmd.data_count + {2'b00, q_rd.cmd.has_status};
   assign is_data  = (idx_ff < q_rd.cmd.data_count);
   assign is_last  = ((idx_ff + 3'd1) == total);
   assign out_free = !valid_ff || rsp_chan.ready;
   assign emit     = q_rd.not_empty && out_free;
   assign q_pop    = emit && is_last;

   assign rsp_chan.valid    = valid_ff;
   assign rsp_chan.out_kind = kind_ff;
   assign rsp_chan.out_byte = byte_ff;
   assign rsp_chan.status   = status_ff;
   assign rsp_chan.run_last = last_ff;

   // output register and position within the head command
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         if (emit) begin
            valid_ff <= 1'b1;
            idx_ff   <= is_last ? 3'd0 : idx_ff + 3'd1;
         end else if (rsp_chan.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         last_ff <= is_last;
         if (is_data) begin
            kind_ff   <= KIND_DATA;
            byte_ff   <= q_rd.cmd.data[idx_ff[1:0]];
            status_ff <= ST_OK;
         end else begin
            kind_ff   <= KIND_STATUS;
            byte_ff   <= 8'h00;
            status_ff <= q_rd.cmd.status;
         end
      end
   end

endmodule

// File: rtl/json_string_unescape.sv
`timescale 1ns / 1ps
// json_string_unescape: top level of the json string unescaper
// depends on jsu_pkg, jsu_if, jsu_front, jsu_queue and jsu_back
//
// Takes one raw byte of JSON text per cycle on req_chan and delivers decoded
// UTF-8 bytes and end of string status results on rsp_chan, at most one
// result per cycle. A byte enters the parser front in the cycle it is
// transferred, so with rsp_chan always ready the block sustains one byte per
// cycle for bytes that make one result. A byte that makes several results
// (a 2 to 4 byte UTF-8 sequence, or data followed by a truncation status,
// up to five in all) holds the result port until all of them are sent; a four
// entry command queue between parser and result stage absorbs such bursts,
// and req_chan.ready drops only while that queue is full. There are no
// configuration registers and no clearing pass after reset.

module json_string_unescape
   import jsu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   jsu_req_if.sink   req_chan,
   jsu_rsp_if.source rsp_chan
);

   qwr_type q_wr;
   qrd_type q_rd;
   logic    q_full;
   logic    q_pop;

   // parser front
   jsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_wr     (q_wr)
   );

   // command queue
   jsu_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_full (q_full),
      .q_rd   (q_rd),
      .q_pop  (q_pop)
   );

   // result back
   jsu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_rd     (q_rd),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: dv/tb_json_string_unescape.sv
`timescale 1ns / 1ps
// tb_json_string_unescape: self-checking bench for the json string unescaper
// depends on jsu_pkg, jsu_if and json_string_unescape; directed rows, then random strings

module tb_json_string_unescape;
   import jsu_pkg::*;

   // one decoded result as seen on rsp_chan
   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic [2:0] status;
      logic       run_last;
   } unesc_result_type;

   // how a directed row gets its expectation
   typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_ONE} row_mode_type;

   typedef struct packed {
      logic [7:0]   b;
      logic         eoi;
      row_mode_type mode;
      logic         kind;
      logic [7:0]   data;
      logic [2:0]   st;
   } dir_row_type;

   typedef struct packed {
      logic [7:0] b;
      logic       eoi;
   } raw_item_type;

   // parser phases of the string scanner
   typedef enum logic [3:0] {
      P_OPEN, P_TEXT, P_ESC, P_HEX, P_PAIR_BS, P_PAIR_U, P_PAIR_HEX, P_DRAIN
   } scan_phase_type;

   typedef enum int {
      BRK_NONE, BRK_OPEN, BRK_CONTROL, BRK_ESCAPE, BRK_HEX, BRK_PAIR, BRK_LONE, BRK_TRUNC
   } break_kind_type;

   localparam int RANDOM_ITEMS = 225;

   localparam logic [7:0] ESC_CHARS [0:7] = '{
      8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74
   };

   // directed rows: byte, end flag, mode, typed kind / byte / status
   localparam dir_row_type DIRECTED [0:50] = '{
      // wrong first byte, draining, end of input while draining
      '{8'h00, 1'b0, ROW_ONE,  KIND_STATUS, 8'h00, ST_NO_OPEN},
      '{8'h22, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'hFF, 1'b1, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      // open, byte extremes
      '{8'h22, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h20, 1'b0, ROW_ONE,  KIND_DATA,   8'h20, ST_OK},
      '{8'hFF, 1'b0, ROW_ONE,  KIND_DATA,   8'hFF, ST_OK},
      // the eight short escapes
      '{8'h5C, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h22, 1'b0, ROW_ONE,  KIND_DATA,   8'h22, ST_OK},
      '{8'h5C, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h5C, 1'b0, ROW_ONE,  KIND_DATA,   8'h5C, ST_OK},
      '{8'h5C, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h2F, 1'b0, ROW_ONE,  KIND_DATA,   8'h2F, ST_OK},
      '{8'h5C, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h62, 1'b0, ROW_ONE,  KIND_DATA,   8'h08, ST_OK},
      '{8'h5C, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h66, 1'b0, ROW_ONE,  KIND_DATA,   8'h0C, ST_OK},
      '{8'h5C, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h6E, 1'b0, ROW_ONE,  KIND_DATA,   8'h0A, ST_OK},
      '{8'h5C, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h72, 1'b0, ROW_ONE,  KIND_DATA,   8'h0D, ST_OK},
      '{8'h5C, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h74, 1'b0, ROW_ONE,  KIND_DATA,   8'h09, ST_OK},
      // closing quote, then reopen
      '{8'h22, 1'b0, ROW_ONE,  KIND_STATUS, 8'h00, ST_OK},
      '{8'h22, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      // raw control byte carrying the end mark
      '{8'h1F, 1'b1, ROW_ONE,  KIND_STATUS, 8'h00, ST_CONTROL},
      // unknown escape
      '{8'h22, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h5C, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h71, 1'b1, ROW_ONE,  KIND_STATUS, 8'h00, ST_BAD_ESC},
      // bad hex digit
      '{8'h22, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h5C, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h75, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h47, 1'b1, ROW_ONE,  KIND_STATUS, 8'h00, ST_BAD_HEX},
      // lone low surrogate \udC00
      '{8'h22, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h5C, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h75, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h64, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h43, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h30, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h30, 1'b1, ROW_ONE,  KIND_STATUS, 8'h00, ST_LONE_LOW},
      // high surrogate \uD800 followed by a plain byte
      '{8'h22, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h5C, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h75, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h44, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h38, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h30, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h30, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ST_OK},
      '{8'h41, 1'b1, ROW_ONE,  KIND_STATUS, 8'h00, ST_UNPAIRED},
      // end of input inside the string: after data, and halfway through an escape
      '{8'h22, 1'b0, ROW_NONE,    KIND_DATA,   8'h00, ST_OK},
      '{8'h41, 1'b1, ROW_PREDICT, KIND_DATA,   8'h00, ST_OK},
      '{8'h22, 1'b0, ROW_NONE,    KIND_DATA,   8'h00, ST_OK},
      '{8'h5C, 1'b1, ROW_ONE,     KIND_STATUS, 8'h00, ST_TRUNCATED}
   };

   logic clock;
   logic reset;

   jsu_req_if req_bus ();
   jsu_rsp_if rsp_bus ();

   json_string_unescape dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // scanner state of the predictor
   scan_phase_type   scan_phase;
   logic [1:0]       digit_count;
   logic [15:0]      code_acc;
   logic [9:0]       high_bits;
   unesc_result_type step_res [0:4];
   int               step_count;

   unesc_result_type expected_decode [$];
   raw_item_type     stim_q [$];

   int src_idle_pct;
   int snk_idle_pct;
   int error_count;
   int items_sent;
   int results_checked;
   int strings_ok;
   int error_ends;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard limit on run length
   initial begin
      #2_000_000;
      $display("json_string_unescape test failed");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void enter_phase(scan_phase_type p);
      scan_phase  = p;
      digit_count = '0;
      code_acc    = '0;
   endfunction

   function automatic void add_result(logic kind, logic [7:0] b, logic [2:0] st);
      step_res[step_count] = '{kind, b, st, 1'b0};
      step_count++;
   endfunction

   function automatic void add_utf8(logic [20:0] cp);
      if (cp <= 21'h7F) begin
         add_result(KIND_DATA, cp[7:0], ST_OK);
      end else if (cp <= 21'h7FF) begin
         add_result(KIND_DATA, {3'b110, cp[10:6]}, ST_OK);
         add_result(KIND_DATA, {2'b10, cp[5:0]}, ST_OK);
      end else if (cp <= 21'hFFFF) begin
         add_result(KIND_DATA, {4'b1110, cp[15:12]}, ST_OK);
         add_result(KIND_DATA, {2'b10, cp[11:6]}, ST_OK);
         add_result(KIND_DATA, {2'b10, cp[5:0]}, ST_OK);
      end else begin
         add_result(KIND_DATA, {5'b11110, cp[20:18]}, ST_OK);
         add_result(KIND_DATA, {2'b10, cp[17:12]}, ST_OK);
         add_result(KIND_DATA, {2'b10, cp[11:6]}, ST_OK);
         add_result(KIND_DATA, {2'b10, cp[5:0]}, ST_OK);
      end
   endfunction

   // digit value, 16 for a byte that is no hex digit
   function automatic logic [4:0] hex_value(logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return 5'(b - 8'h30);
      if (b >= 8'h61 && b <= 8'h66) return 5'(b - 8'h61 + 8'd10);
      if (b >= 8'h41 && b <= 8'h46) return 5'(b - 8'h41 + 8'd10);
      return 5'd16;
   endfunction

   // results caused by one raw byte, left in step_res
   function automatic void decode_raw_byte(logic [7:0] b, logic eoi);
      logic [2:0] err;
      logic       ended;
      logic [4:0] dv;
      err        = ST_OK;
      ended      = 1'b0;
      step_count = 0;
      case (scan_phase)
         P_OPEN: begin
            if (b == 8'h22) scan_phase = P_TEXT;
            else err = ST_NO_OPEN;
         end
         P_TEXT: begin
            if (b == 8'h22) begin
               add_result(KIND_STATUS, 8'h00, ST_OK);
               enter_phase(P_OPEN);
               ended = 1'b1;
            end else if (b < 8'h20) begin
               err = ST_CONTROL;
            end else if (b == 8'h5C) begin
               scan_phase = P_ESC;
            end else begin
               add_result(KIND_DATA, b, ST_OK);
            end
         end
         P_ESC: begin
            scan_phase = P_TEXT;
            case (b)
               8'h22, 8'h5C, 8'h2F: add_result(KIND_DATA, b, ST_OK);
               8'h62: add_result(KIND_DATA, 8'h08, ST_OK);
               8'h66: add_result(KIND_DATA, 8'h0C, ST_OK);
               8'h6E: add_result(KIND_DATA, 8'h0A, ST_OK);
               8'h72: add_result(KIND_DATA, 8'h0D, ST_OK);
               8'h74: add_result(KIND_DATA, 8'h09, ST_OK);
               8'h75: enter_phase(P_HEX);
               default: err = ST_BAD_ESC;
            endcase
         end
         P_HEX, P_PAIR_HEX: begin
            dv = hex_value(b);
            if (dv[4]) begin
               err = ST_BAD_HEX;
            end else begin
               code_acc = {code_acc[11:0], dv[3:0]};
               if (digit_count != 2'd3) begin
                  digit_count = digit_count + 2'd1;
               end else if (scan_phase == P_HEX) begin
                  // first \u of a code point
                  digit_count = '0;
                  if (code_acc >= 16'hD800 && code_acc <= 16'hDBFF) begin
                     high_bits = code_acc[9:0];
                     enter_phase(P_PAIR_BS);
                  end else if (code_acc >= 16'hDC00 && code_acc <= 16'hDFFF) begin
                     err = ST_LONE_LOW;
                  end else begin
                     add_utf8({5'd0, code_acc});
                     enter_phase(P_TEXT);
                  end
               end else begin
                  // low half of a surrogate pair
                  digit_count = '0;
                  if (code_acc >= 16'hDC00 && code_acc <= 16'hDFFF) begin
                     add_utf8(21'h10000 + {high_bits, code_acc[9:0]});
                     enter_phase(P_TEXT);
                  end else begin
                     err = ST_UNPAIRED;
                  end
               end
            end
         end
         P_PAIR_BS: begin
            if (b == 8'h5C) scan_phase = P_PAIR_U;
            else err = ST_UNPAIRED;
         end
         P_PAIR_U: begin
            if (b == 8'h75) enter_phase(P_PAIR_HEX);
            else err = ST_UNPAIRED;
         end
         default: begin
            if (eoi) enter_phase(P_OPEN);
            ended = 1'b1;
         end
      endcase

      // error ends the string, then drain unless this byte carries the end mark
      if (err != ST_OK) begin
         add_result(KIND_STATUS, 8'h00, err);
         enter_phase(eoi ? P_OPEN : P_DRAIN);
         ended = 1'b1;
      end
      if (!ended && eoi) begin
         add_result(KIND_STATUS, 8'h00, ST_TRUNCATED);
         enter_phase(P_OPEN);
      end
      if (step_count > 0) step_res[step_count-1].run_last = 1'b1;
   endfunction

   // ---------------------------------------------------------------- stimulus

   // append one raw item at the tail of the stimulus queue
   function automatic void append_stim(raw_item_type t);
      stim_q.insert(stim_q.size(), t);
   endfunction

   function automatic void push_raw(logic [7:0] b);
      append_stim('{b, 1'b0});
   endfunction

   function automatic void mark_end();
      raw_item_type t;
      t     = stim_q.pop_back();
      t.eoi = 1'b1;
      append_stim(t);
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
   endfunction

   function automatic void push_hex4(logic [15:0] v);
      for (int i = 3; i >= 0; i--) push_raw(hex_char(v[i*4 +: 4]));
   endfunction

   // one well-formed piece of string content
   function automatic void push_token();
      int          sel;
      logic [7:0]  b;
      logic [15:0] cp;
      sel = $urandom_range(0, 9);
      if (sel <= 4) begin
         do b = 8'($urandom_range(32, 255)); while (b == 8'h22 || b == 8'h5C);
         push_raw(b);
      end else if (sel <= 6) begin
         push_raw(8'h5C);
         push_raw(ESC_CHARS[$urandom_range(0, 7)]);
      end else if (sel == 7) begin
         // surrogate pair
         push_raw(8'h5C);
         push_raw(8'h75);
         push_hex4({6'b110110, 10'($urandom)});
         push_raw(8'h5C);
         push_raw(8'h75);
         push_hex4({6'b110111, 10'($urandom)});
      end else begin
         case ($urandom_range(0, 3))
            0:       cp = 16'($urandom_range(0, 16'h7F));
            1:       cp = 16'($urandom_range(16'h80, 16'h7FF));
            2:       cp = 16'($urandom_range(16'h800, 16'hD7FF));
            default: cp = 16'($urandom_range(16'hE000, 16'hFFFF));
         endcase
         push_raw(8'h5C);
         push_raw(8'h75);
         push_hex4(cp);
      end
   endfunction

   // one string, mostly well formed, sometimes broken or pure noise
   function automatic void build_string();
      break_kind_type brk;
      logic [7:0]     b;
      logic [15:0]    cp;
      if ($urandom_range(0, 99) < 5) begin
         repeat ($urandom_range(1, 4)) append_stim('{8'($urandom), 1'($urandom)});
         return;
      end
      brk = ($urandom_range(0, 99) < 70) ? BRK_NONE : break_kind_type'($urandom_range(1, 7));
      if (brk == BRK_OPEN) begin
         do b = 8'($urandom); while (b == 8'h22);
         push_raw(b);
      end else begin
         push_raw(8'h22);
         repeat ($urandom_range(0, 6)) push_token();
      end
      case (brk)
         BRK_NONE: begin
            push_raw(8'h22);
            if ($urandom_range(0, 3) == 0) mark_end();
         end
         // the wrong first byte is already queued
         BRK_OPEN: begin
         end
         BRK_CONTROL: push_raw(8'($urandom_range(0, 31)));
         BRK_ESCAPE: begin
            push_raw(8'h5C);
            do b = 8'($urandom);
            while (b inside {8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74, 8'h75});
            push_raw(b);
         end
         BRK_HEX: begin
            push_raw(8'h5C);
            push_raw(8'h75);
            repeat ($urandom_range(0, 3)) push_raw(hex_char(4'($urandom)));
            do b = 8'($urandom); while (hex_value(b) < 5'd16);
            push_raw(b);
         end
         BRK_PAIR: begin
            push_raw(8'h5C);
            push_raw(8'h75);
            push_hex4({6'b110110, 10'($urandom)});
            case ($urandom_range(0, 2))
               0: begin
                  do b = 8'($urandom); while (b == 8'h5C);
                  push_raw(b);
               end
               1: begin
                  push_raw(8'h5C);
                  do b = 8'($urandom); while (b == 8'h75);
                  push_raw(b);
               end
               default: begin
                  push_raw(8'h5C);
                  push_raw(8'h75);
                  do cp = 16'($urandom); while (cp >= 16'hDC00 && cp <= 16'hDFFF);
                  push_hex4(cp);
               end
            endcase
         end
         BRK_LONE: begin
            push_raw(8'h5C);
            push_raw(8'h75);
            push_hex4({6'b110111, 10'($urandom)});
         end
         default: begin
            // end mark somewhere inside a surrogate pair, or right after content
            push_raw(8'h5C);
            push_raw(8'h75);
            push_hex4({6'b110110, 10'($urandom)});
            push_raw(8'h5C);
            push_raw(8'h75);
            push_hex4({6'b110111, 10'($urandom)});
            repeat ($urandom_range(1, 12)) void'(stim_q.pop_back());
            mark_end();
         end
      endcase
      // after an error: end mark on the error byte, or a few drained bytes
      if (brk != BRK_NONE && brk != BRK_TRUNC) begin
         if ($urandom_range(0, 2) == 0) begin
            mark_end();
         end else begin
            repeat ($urandom_range(0, 3)) push_raw(8'($urandom));
            append_stim('{8'($urandom), 1'b1});
         end
      end
   endfunction

   // one transfer on req_chan, entered and left at a falling edge
   task automatic send_item(input logic [7:0] b, input logic eoi, input row_mode_type mode,
                            input unesc_result_type typed);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.data_byte    <= b;
      req_bus.end_of_input <= eoi;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      decode_raw_byte(b, eoi);
      if (mode == ROW_PREDICT) begin
         for (int i = 0; i < step_count; i++) begin
            expected_decode.insert(expected_decode.size(), step_res[i]);
         end
      end else if (mode == ROW_ONE) begin
         expected_decode.insert(expected_decode.size(), typed);
      end
      items_sent++;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------- result side

   // random back pressure on rsp_chan
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin : check_results
      unesc_result_type got;
      unesc_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.out_kind, rsp_bus.out_byte, rsp_bus.status, rsp_bus.run_last};
         if (expected_decode.size() == 0) begin
            $display("%0t: unexpected result kind=%0d byte=%02h status=%0d last=%0d",
                     $time, got.kind, got.data, got.status, got.run_last);
            error_count++;
         end else begin
            want = expected_decode.pop_front();
            results_checked++;
            if (got.kind !== want.kind || got.data !== want.data ||
                got.status !== want.status || got.run_last !== want.run_last) begin
               $display("%0t: mismatch expected kind=%0d byte=%02h status=%0d last=%0d",
                        $time, want.kind, want.data, want.status, want.run_last);
               $display("%0t:          actual   kind=%0d byte=%02h status=%0d last=%0d",
                        $time, got.kind, got.data, got.status, got.run_last);
               error_count++;
            end
            if (want.kind == KIND_STATUS) begin
               if (want.status == ST_OK) strings_ok++;
               else error_ends++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      raw_item_type     item;
      unesc_result_type typed;
      int               random_sent;
      int               guard;
      req_bus.valid        <= 1'b0;
      req_bus.data_byte    <= 8'h00;
      req_bus.end_of_input <= 1'b0;
      reset                <= 1'b1;
      src_idle_pct    = 20;
      snk_idle_pct    = 52;
      error_count     = 0;
      items_sent      = 0;
      results_checked = 0;
      strings_ok      = 0;
      error_ends      = 0;
      random_sent     = 0;
      enter_phase(P_OPEN);
      high_bits = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows
      for (int r = 0; r < $size(DIRECTED); r++) begin
         typed = '{DIRECTED[r].kind, DIRECTED[r].data, DIRECTED[r].st, 1'b1};
         send_item(DIRECTED[r].b, DIRECTED[r].eoi, DIRECTED[r].mode, typed);
      end

      // random strings in three idling phases
      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent >= 2 * RANDOM_ITEMS / 3) begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
         end else if (random_sent >= RANDOM_ITEMS / 3) begin
            src_idle_pct = 52;
            snk_idle_pct = 20;
         end
         build_string();
         while (stim_q.size() != 0) begin
            item = stim_q.pop_front();
            send_item(item.b, item.eoi, ROW_PREDICT, '0);
            random_sent++;
         end
      end
      req_bus.valid <= 1'b0;

      // let outstanding results drain
      guard = 0;
      while (expected_decode.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (16) @(posedge clock);
      if (expected_decode.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_decode.size());
         error_count++;
      end

      $display("covered %0d input bytes (%0d directed), %0d results checked",
               items_sent, $size(DIRECTED), results_checked);
      $display("strings closed ok: %0d, strings ended by an error status: %0d",
               strings_ok, error_ends);
      if (error_count == 0) begin
         $display("json_string_unescape test passed");
      end else begin
         $display("json_string_unescape test failed");
      end
      $finish;
   end

endmodule
